// ===== sv/qrs_pkg.sv =====
package qrs_pkg;

    localparam int CoefWidth = 16;
    localparam int DiscWidth = 2 * CoefWidth + 2;           // b*b - 4ac, signed
    localparam int SqrtWidth = CoefWidth + 1;               // floor sqrt of disc
    localparam int NumWidth  = CoefWidth + 2;               // -b +/- s
    localparam int DenWidth  = CoefWidth + 1;               // 2a
    localparam int QuoWidth  = NumWidth;                    // unsigned quotient bits
    localparam int RootWidth = 17;
    localparam int SqrtSteps = SqrtWidth;
    localparam int DivSteps  = QuoWidth;

    typedef enum logic [1:0] {
        STATUS_NONE = 2'd0,
        STATUS_ONE  = 2'd1,
        STATUS_TWO  = 2'd2,
        STATUS_AZERO = 2'd3
    } status_t;

    // Data carried from cell to cell down the square root chain
    typedef struct packed {
        logic                        valid;
        status_t                     status;
        logic signed [CoefWidth-1:0] coef_a;
        logic signed [CoefWidth-1:0] coef_b;
        logic [DiscWidth-1:0]        rem;
        logic [SqrtWidth-1:0]        root;
    } sqrt_cell_t;

    // Data carried from cell to cell down the divider chain (two lanes)
    typedef struct packed {
        logic                        valid;
        status_t                     status;
        logic                        neg_first;
        logic                        neg_second;
        logic [DenWidth-1:0]         den;
        logic [NumWidth-1:0]         rem_first;
        logic [NumWidth-1:0]         rem_second;
        logic [NumWidth-1:0]         num_first;
        logic [NumWidth-1:0]         num_second;
    } div_cell_t;

    function automatic logic [RootWidth-1:0] sat_root(input logic neg,
                                                      input logic [QuoWidth-1:0] mag);
        begin
            if (neg) begin
                if (mag > QuoWidth'(65536)) sat_root = RootWidth'(17'h10000);
                else sat_root = RootWidth'(-{1'b0, mag});
            end else begin
                if (mag > QuoWidth'(65535)) sat_root = RootWidth'(17'h0FFFF);
                else sat_root = RootWidth'(mag);
            end
        end
    endfunction

endpackage

// ===== sv/qrs_sqrt_cell.sv =====
module qrs_sqrt_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [5:0]            step,
    input  qrs_pkg::sqrt_cell_t   cell_in,
    output qrs_pkg::sqrt_cell_t   cell_out
);

    qrs_pkg::sqrt_cell_t cell_reg, cell_next;
    logic [qrs_pkg::DiscWidth+1:0] trial;
    logic [qrs_pkg::DiscWidth-1:0] rem_top;

    // One restoring step: try the next root bit
    always_comb begin
        cell_next = cell_in;
        rem_top = cell_in.rem >> (2 * step);
        trial = (qrs_pkg::DiscWidth+2)'(rem_top) -
                (qrs_pkg::DiscWidth+2)'({cell_in.root, 2'b01});
        if (!trial[qrs_pkg::DiscWidth+1]) begin
            cell_next.root = {cell_in.root[qrs_pkg::SqrtWidth-2:0], 1'b1};
            cell_next.rem  = (cell_in.rem & ~(~'0 << (2 * step))) |
                             (qrs_pkg::DiscWidth'(trial) << (2 * step));
        end else begin
            cell_next.root = {cell_in.root[qrs_pkg::SqrtWidth-2:0], 1'b0};
        end
    end

    // Hand to the neighbor when the chain advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== sv/qrs_div_cell.sv =====
module qrs_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [4:0]           step,
    input  qrs_pkg::div_cell_t   cell_in,
    output qrs_pkg::div_cell_t   cell_out
);

    qrs_pkg::div_cell_t cell_reg, cell_next;
    logic [qrs_pkg::NumWidth:0] part_first, part_second;

    // One quotient bit per lane: shift in the next numerator bit, subtract
    always_comb begin
        cell_next = cell_in;
        part_first  = {cell_in.rem_first, cell_in.num_first[step]};
        part_second = {cell_in.rem_second, cell_in.num_second[step]};
        cell_next.num_first[step]  = 1'b0;
        cell_next.num_second[step] = 1'b0;
        cell_next.rem_first  = qrs_pkg::NumWidth'(part_first);
        cell_next.rem_second = qrs_pkg::NumWidth'(part_second);
        if (part_first >= (qrs_pkg::NumWidth+1)'(cell_in.den)) begin
            cell_next.rem_first = qrs_pkg::NumWidth'(part_first -
                                  (qrs_pkg::NumWidth+1)'(cell_in.den));
            cell_next.num_first[step] = 1'b1;
        end
        if (part_second >= (qrs_pkg::NumWidth+1)'(cell_in.den)) begin
            cell_next.rem_second = qrs_pkg::NumWidth'(part_second -
                                   (qrs_pkg::NumWidth+1)'(cell_in.den));
            cell_next.num_second[step] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== sv/quadratic_root_solver_top.sv =====
// Quadratic root solver.
// Input channel s_*: one transaction carries coef_a, coef_b, coef_c (signed 16 bit)
// packed in s_axis_tdata. Output channel m_*: one transaction per input, carrying
// root_status, root_first, root_second in m_axis_tdata.
// Status: 0 no real root, 1 one root, 2 two roots, 3 leading coefficient zero;
// root fields are zero where unused, roots truncate toward zero.
// The pipeline is a products register and a discriminant register (multiply, then
// subtract for the discriminant), a chain of 17 square root cells (one root bit each),
// a chain of 18 divider cells (one quotient bit per root each), and the output register.
// Throughput is one transaction per cycle while the receiver does not stall; every stage
// hands its data to the next one whenever the chain advances.
// The whole chain advances only when the output register is empty or being taken,
// so a stalled receiver holds every stage in place and s_axis_tready falls with it.
// Reset (aresetn low, synchronous) drops all in-flight transactions and leaves the
// output channel empty.
module quadratic_root_solver_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status [1:0], first [18:2], second [35:19]
);

    localparam int CW = qrs_pkg::CoefWidth;
    localparam int DW = qrs_pkg::DiscWidth;

    logic en;
    logic out_valid_reg;
    logic [35:0] out_data_reg, out_data_next;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: products
    logic                 v1_reg;
    logic signed [CW-1:0] a1_reg, b1_reg;
    logic signed [2*CW-1:0] bb_reg, ac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_axis_tvalid;
            a1_reg <= s_axis_tdata[CW-1:0];
            b1_reg <= s_axis_tdata[2*CW-1:CW];
            bb_reg <= $signed(s_axis_tdata[2*CW-1:CW]) * $signed(s_axis_tdata[2*CW-1:CW]);
            ac_reg <= $signed(s_axis_tdata[CW-1:0]) * $signed(s_axis_tdata[3*CW-1:2*CW]);
        end
    end

    // Stage 2: discriminant and status
    qrs_pkg::sqrt_cell_t sq_chain [0:qrs_pkg::SqrtSteps];
    logic signed [DW-1:0] disc;

    always_comb begin
        disc = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_chain[0].valid <= 1'b0;
        end else if (en) begin
            sq_chain[0].valid  <= v1_reg;
            sq_chain[0].coef_a <= a1_reg;
            sq_chain[0].coef_b <= b1_reg;
            sq_chain[0].root   <= '0;
            sq_chain[0].rem    <= disc[DW-1] ? '0 : disc;
            if (a1_reg == '0)        sq_chain[0].status <= qrs_pkg::STATUS_AZERO;
            else if (disc[DW-1])     sq_chain[0].status <= qrs_pkg::STATUS_NONE;
            else if (disc == '0)     sq_chain[0].status <= qrs_pkg::STATUS_ONE;
            else                     sq_chain[0].status <= qrs_pkg::STATUS_TWO;
        end
    end

    // Square root chain, most significant root bit first
    genvar gi;
    generate
        for (gi = 0; gi < qrs_pkg::SqrtSteps; gi++) begin : g_sqrt
            qrs_sqrt_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .step    (6'(qrs_pkg::SqrtSteps - 1 - gi)),
                .cell_in (sq_chain[gi]),
                .cell_out(sq_chain[gi+1])
            );
        end
    endgenerate

    // Numerators and signs for the divider chain
    qrs_pkg::div_cell_t dv_chain [0:qrs_pkg::DivSteps];
    qrs_pkg::sqrt_cell_t sq_last;
    logic signed [qrs_pkg::NumWidth-1:0] nb, sv, n1, n2;
    logic signed [qrs_pkg::DenWidth-1:0] den_s;

    always_comb begin
        sq_last = sq_chain[qrs_pkg::SqrtSteps];
        nb = -qrs_pkg::NumWidth'(sq_last.coef_b);
        sv = (sq_last.status == qrs_pkg::STATUS_TWO) ?
             $signed(qrs_pkg::NumWidth'(sq_last.root)) : '0;
        n1 = nb + sv;
        n2 = nb - sv;
        den_s = qrs_pkg::DenWidth'(sq_last.coef_a) <<< 1;
        dv_chain[0].valid      = sq_last.valid;
        dv_chain[0].status     = sq_last.status;
        dv_chain[0].neg_first  = n1[qrs_pkg::NumWidth-1] ^ den_s[qrs_pkg::DenWidth-1];
        dv_chain[0].neg_second = n2[qrs_pkg::NumWidth-1] ^ den_s[qrs_pkg::DenWidth-1];
        dv_chain[0].den        = den_s[qrs_pkg::DenWidth-1] ? -den_s : den_s;
        dv_chain[0].num_first  = n1[qrs_pkg::NumWidth-1] ? -n1 : n1;
        dv_chain[0].num_second = n2[qrs_pkg::NumWidth-1] ? -n2 : n2;
        dv_chain[0].rem_first  = '0;
        dv_chain[0].rem_second = '0;
    end

    generate
        for (gi = 0; gi < qrs_pkg::DivSteps; gi++) begin : g_div
            qrs_div_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .step    (5'(qrs_pkg::DivSteps - 1 - gi)),
                .cell_in (dv_chain[gi]),
                .cell_out(dv_chain[gi+1])
            );
        end
    endgenerate

    // Output formatting: saturate, zero unused roots
    qrs_pkg::div_cell_t dv_last;
    logic [qrs_pkg::RootWidth-1:0] r1, r2;

    always_comb begin
        dv_last = dv_chain[qrs_pkg::DivSteps];
        r1 = '0;
        r2 = '0;
        case (dv_last.status)
            qrs_pkg::STATUS_ONE: begin
                r1 = qrs_pkg::sat_root(dv_last.neg_first, dv_last.num_first);
            end
            qrs_pkg::STATUS_TWO: begin
                r1 = qrs_pkg::sat_root(dv_last.neg_first, dv_last.num_first);
                r2 = qrs_pkg::sat_root(dv_last.neg_second, dv_last.num_second);
            end
            default: begin
                r1 = '0;
            end
        endcase
        out_data_next = {r2, r1, dv_last.status};
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_last.valid;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_data_reg};

endmodule

// ===== sim/tb_quadratic_root_solver_top.sv =====
`timescale 1ns / 1ps

module tb_quadratic_root_solver_top;

    typedef struct {
        qrs_pkg::status_t status;
        logic [16:0]      first;
        logic [16:0]      second;
    } roots_t;

    // Integer floor square root, bit by bit
    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned rem, root, bitv;
        begin
            rem = n;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        end
    endfunction

    // Clamp a root to the 17 bit signed range
    function automatic logic [16:0] clamp_root(input longint v);
        begin
            if (v < -65536) v = -65536;
            if (v > 65535) v = 65535;
            return v[16:0];
        end
    endfunction

    function automatic roots_t solve_roots(input logic [47:0] coefs);
        roots_t r;
        longint a, b, c, disc, den, s;
        begin
            a = longint'($signed(coefs[15:0]));
            b = longint'($signed(coefs[31:16]));
            c = longint'($signed(coefs[47:32]));
            r.status = qrs_pkg::STATUS_NONE;
            r.first = '0;
            r.second = '0;
            if (a == 0) begin
                r.status = qrs_pkg::STATUS_AZERO;
            end else begin
                disc = b * b - 4 * a * c;
                den = 2 * a;
                if (disc == 0) begin
                    r.status = qrs_pkg::STATUS_ONE;
                    r.first = clamp_root((-b) / den);
                end else if (disc > 0) begin
                    s = longint'(isqrt(disc));
                    r.status = qrs_pkg::STATUS_TWO;
                    r.first = clamp_root((-b + s) / den);
                    r.second = clamp_root((-b - s) / den);
                end
            end
            return r;
        end
    endfunction

    class root_scoreboard;
        roots_t pending[$];
        int     errors;

        function void note_coefs(logic [47:0] coefs);
            pending.push_back(solve_roots(coefs));
        endfunction

        function void check_roots(logic [39:0] data);
            roots_t e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[1:0] !== e.status) begin
                $error("root_status expected %0d actual %0d", e.status, data[1:0]);
                errors++;
            end
            if (data[18:2] !== e.first) begin
                $error("root_first expected %0d actual %0d",
                       $signed(e.first), $signed(data[18:2]));
                errors++;
            end
            if (data[35:19] !== e.second) begin
                $error("root_second expected %0d actual %0d",
                       $signed(e.second), $signed(data[35:19]));
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;

    root_scoreboard sb = new();
    bit  quiet_tail = 0;
    bit  hold_sink = 0;
    int  cycles = 0;

    always #5 aclk = ~aclk;

    quadratic_root_solver_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_axis_tvalid && s_axis_tready) sb.note_coefs(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_roots(m_axis_tdata);
    end

    // Timeout guard
    always @(posedge aclk) begin
        if (cycles > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive the receiver: random stall bursts, or one long counted hold when asked
    initial begin
        int n;
        @(negedge aclk);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 0;
                repeat (300) @(negedge aclk);
                hold_sink = 0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 0;
                n = $urandom_range(1, 8);
                repeat (n) @(negedge aclk);
            end else begin
                m_axis_tready <= 1;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge aclk);
            end
        end
    end

    // Offer one coefficient set and wait for its transaction
    task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c);
        int n;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            n = $urandom_range(1, 8);
            repeat (n) @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {c, b, a};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random set: small magnitudes half the time so every status shows up often
    task automatic send_random();
        logic [15:0] a, b, c;
        int r, k, x1, x2;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            a = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
        end else if (r < 6) begin
            a = 16'($signed($urandom_range(0, 40)) - 20);
            b = 16'($signed($urandom_range(0, 200)) - 100);
            c = 16'($signed($urandom_range(0, 200)) - 100);
        end else if (r < 8) begin
            // build from integer roots: k(x-x1)(x-x2)
            k = int'($urandom_range(1, 6)) * ($urandom_range(0, 1) ? 1 : -1);
            x1 = int'($urandom_range(0, 60)) - 30;
            x2 = $urandom_range(0, 1) ? x1 : int'($urandom_range(0, 60)) - 30;
            a = 16'(k); b = 16'(-k * (x1 + x2)); c = 16'(k * x1 * x2);
        end else if (r == 8) begin
            a = 16'd0; b = 16'($urandom); c = 16'($urandom);
        end else begin
            a = $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            b = 16'($urandom); c = 16'($urandom);
        end
        send_coefs(a, b, c);
    endtask

    initial begin
        int i, w;
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: extremes and each status
        send_coefs(16'd0, 16'd5, 16'd3);
        send_coefs(16'd0, 16'd0, 16'd0);
        send_coefs(16'd1, 16'd0, 16'd1);
        send_coefs(16'd1, 16'd2, 16'd1);
        send_coefs(16'd1, 16'hFFFD, 16'd2);
        send_coefs(16'd2, 16'd1, 16'hFFFF);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_coefs(16'h7FFF, 16'h8000, 16'h8000);
        send_coefs(16'h8000, 16'h7FFF, 16'h7FFF);
        send_coefs(16'd1, 16'h8000, 16'd0);
        send_coefs(16'hFFFF, 16'h7FFF, 16'h7FFF);
        send_coefs(16'd1, 16'h8000, 16'h8000);
        send_coefs(16'hFFFF, 16'h8000, 16'h7FFF);
        send_coefs(16'h0001, 16'h0000, 16'h8000);
        send_coefs(16'hFFFF, 16'd0, 16'd0);
        send_coefs(16'd3, 16'd7, 16'hFFFB);
        send_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Random with long receiver hold partway through
        for (i = 0; i < 1800; i++) begin
            if (i == 300) hold_sink = 1;
            if (i == 1500) quiet_tail = 1;
            send_random();
        end
        s_axis_tvalid <= 0;

        w = 0;
        while (sb.pending.size() != 0 && w < 20000) begin
            @(posedge aclk);
            w++;
        end
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
